@@ hdl/sta_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the smoothed threshold alarm.
// No dependencies.
package sta_pkg;

  typedef enum logic [2:0] {
    ACT_SAMPLE     = 3'd0,
    ACT_REBASELINE = 3'd1,
    ACT_CAL_SAMPLE = 3'd2,
    ACT_STOP       = 3'd3,
    ACT_START      = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    REG_THRESHOLD = 3'd0,
    REG_INTERVAL  = 3'd1,
    REG_DEBOUNCE  = 3'd2,
    REG_ALPHA     = 3'd3
  } cfg_reg_t;

  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = 16;

  localparam logic [11:0] THRESHOLD_RST = 12'd55;
  localparam logic [15:0] INTERVAL_RST  = 16'd200;
  localparam logic [15:0] DEBOUNCE_RST  = 16'd1000;
  localparam logic [3:0]  ALPHA_RST     = 4'd3;
  localparam logic [3:0]  ALPHA_FULL    = 4'd10;

  typedef struct packed {
    logic [11:0] threshold;
    logic [15:0] interval;
    logic [15:0] debounce;
    logic [3:0]  alpha;
    logic [3:0]  beta;
  } cfg_t;

  typedef struct packed {
    logic alarm;
    logic digital_level;
    logic sample_taken;
    logic running;
    logic calibration_done;
  } flags_t;

endpackage

@@ hdl/sta_cfg_regs.sv @@
`timescale 1ns / 1ps
// Configuration register file; alpha saturates to ten on write and its
// complement is kept alongside. Depends on sta_pkg.
module sta_cfg_regs import sta_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  output cfg_t                 cfg_o
);

  cfg_t       cfg_r;
  logic [3:0] alpha_sat;

  assign alpha_sat = (cfg_data[3:0] > ALPHA_FULL) ? ALPHA_FULL : cfg_data[3:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold <= THRESHOLD_RST;
      cfg_r.interval  <= INTERVAL_RST;
      cfg_r.debounce  <= DEBOUNCE_RST;
      cfg_r.alpha     <= ALPHA_RST;
      cfg_r.beta      <= ALPHA_FULL - ALPHA_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_THRESHOLD: cfg_r.threshold <= cfg_data[11:0];
        REG_INTERVAL:  cfg_r.interval  <= cfg_data;
        REG_DEBOUNCE:  cfg_r.debounce  <= cfg_data;
        REG_ALPHA: begin
          cfg_r.alpha <= alpha_sat;
          cfg_r.beta  <= ALPHA_FULL - alpha_sat;
        end
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_r;

endmodule

@@ hdl/sta_engine.sv @@
`timescale 1ns / 1ps
// Filter, debounce and calibration state with its update, registered on fire.
// Depends on sta_pkg.
module sta_engine import sta_pkg::*; #(
  parameter int SAMPLE_BITS = 12,
  parameter int CAL_SAMPLES = 10,
  parameter int TIME_BITS   = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   fire,
  input  action_t                action,
  input  logic [TIME_BITS-1:0]   now,
  input  logic [SAMPLE_BITS-1:0] raw,
  input  logic                   dig,
  input  cfg_t                   cfg,
  output logic [SAMPLE_BITS-1:0] filt_o,
  output flags_t                 flags_o
);

  localparam int XW    = SAMPLE_BITS + 4;
  localparam int PW    = 2 * XW + 1;
  localparam int CmpW  = (SAMPLE_BITS > 12) ? SAMPLE_BITS : 12;
  // reciprocal for /10
  localparam int K10   = XW + 4;
  localparam longint M10L = ((longint'(1) <<< K10) + 9) / 10;
  localparam logic [XW:0] M10 = (XW+1)'(M10L);
  // reciprocal for the calibration mean
  localparam int CalL  = $clog2(CAL_SAMPLES);
  localparam int KC    = XW + CalL;
  localparam longint MCL = ((longint'(1) <<< KC) + CAL_SAMPLES - 1) / CAL_SAMPLES;
  localparam logic [XW:0] MC = (XW+1)'(MCL);
  localparam logic [3:0] CalCnt = 4'(CAL_SAMPLES);

  logic [SAMPLE_BITS-1:0] filt_r, filt_nxt;
  logic [TIME_BITS-1:0]   last_r, last_nxt;
  logic [TIME_BITS-1:0]   start_r, start_nxt;
  logic                   pend_r, pend_nxt;
  logic                   alarm_r, alarm_nxt;
  logic                   dig_r, dig_nxt;
  logic                   active_r, active_nxt;
  logic [XW-1:0]          sum_r, sum_nxt;
  logic [3:0]             cnt_r, cnt_nxt;

  logic [TIME_BITS-1:0]   since_sample, since_change;
  logic [XW-1:0]          mix;
  logic [PW-1:0]          mix_prod, cal_prod;
  logic [SAMPLE_BITS-1:0] ema, mean;
  logic [XW-1:0]          sum_inc;
  logic [3:0]             cnt_inc;
  logic                   cond, taken, cal_done;

  assign since_sample = now - last_r;
  assign since_change = now - start_r;
  assign mix      = XW'(cfg.alpha) * XW'(raw) + XW'(cfg.beta) * XW'(filt_r);
  assign mix_prod = PW'(mix) * PW'(M10);
  assign ema      = mix_prod[K10 +: SAMPLE_BITS];
  assign cond     = CmpW'(ema) >= CmpW'(cfg.threshold);
  assign sum_inc  = sum_r + XW'(raw);
  assign cnt_inc  = cnt_r + 4'd1;
  assign cal_prod = PW'(sum_inc) * PW'(MC);
  assign mean     = cal_prod[KC +: SAMPLE_BITS];

  always_comb begin
    filt_nxt   = filt_r;
    last_nxt   = last_r;
    start_nxt  = start_r;
    pend_nxt   = pend_r;
    alarm_nxt  = alarm_r;
    dig_nxt    = dig_r;
    active_nxt = active_r;
    sum_nxt    = sum_r;
    cnt_nxt    = cnt_r;
    taken      = 1'b0;
    cal_done   = 1'b0;
    unique case (action)
      ACT_SAMPLE: begin
        if (active_r && (since_sample >= TIME_BITS'(cfg.interval))) begin
          taken    = 1'b1;
          last_nxt = now;
          filt_nxt = ema;
          dig_nxt  = dig;
          if (cond != alarm_r) begin
            if (!pend_r) begin
              pend_nxt  = 1'b1;
              start_nxt = now;
            end else if (since_change >= TIME_BITS'(cfg.debounce)) begin
              alarm_nxt = cond;
              pend_nxt  = 1'b0;
            end
          end else begin
            pend_nxt = 1'b0;
          end
        end
      end
      ACT_REBASELINE: begin
        filt_nxt  = raw;
        alarm_nxt = 1'b0;
        pend_nxt  = 1'b0;
      end
      ACT_CAL_SAMPLE: begin
        if (cnt_inc >= CalCnt) begin
          filt_nxt = mean;
          sum_nxt  = '0;
          cnt_nxt  = '0;
          cal_done = 1'b1;
        end else begin
          sum_nxt = sum_inc;
          cnt_nxt = cnt_inc;
        end
      end
      ACT_STOP: active_nxt = 1'b0;
      ACT_START: begin
        filt_nxt   = '0;
        last_nxt   = '0;
        start_nxt  = '0;
        pend_nxt   = 1'b0;
        alarm_nxt  = 1'b0;
        dig_nxt    = 1'b0;
        active_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r   <= '0;
      last_r   <= '0;
      start_r  <= '0;
      pend_r   <= 1'b0;
      alarm_r  <= 1'b0;
      dig_r    <= 1'b0;
      active_r <= 1'b0;
      sum_r    <= '0;
      cnt_r    <= '0;
    end else if (fire) begin
      filt_r   <= filt_nxt;
      last_r   <= last_nxt;
      start_r  <= start_nxt;
      pend_r   <= pend_nxt;
      alarm_r  <= alarm_nxt;
      dig_r    <= dig_nxt;
      active_r <= active_nxt;
      sum_r    <= sum_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  assign filt_o                   = filt_nxt;
  assign flags_o.alarm            = alarm_nxt;
  assign flags_o.digital_level    = dig_nxt;
  assign flags_o.sample_taken     = taken;
  assign flags_o.running          = active_nxt;
  assign flags_o.calibration_done = cal_done;

endmodule

@@ hdl/smoothed_threshold_alarm_debounce.sv @@
`timescale 1ns / 1ps
// Smoothed threshold alarm with debounce: top level with request and result
// registers. Depends on sta_pkg, sta_cfg_regs and sta_engine.
//
// Each request yields exactly one result, passing through the request register
// and then the result register. A new request is taken every cycle while the
// output is not stalled; the rate is set by the state update, whose longest
// path is the alpha-weighted sum followed by the constant divide by ten. The
// result register lets the next request enter while a result waits. No clearing
// pass after reset; configuration writes are taken every cycle and must only be
// issued while no request is in flight.
module smoothed_threshold_alarm_debounce import sta_pkg::*; #(
  parameter int SAMPLE_BITS = 12,
  parameter int CAL_SAMPLES = 10,
  parameter int TIME_BITS   = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [2:0]             in_action,
  input  logic [TIME_BITS-1:0]   in_time_ms,
  input  logic [SAMPLE_BITS-1:0] in_raw_sample,
  input  logic                   in_raw_digital,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] out_smoothed_value,
  output logic                   out_alarm,
  output logic                   out_digital_level,
  output logic                   out_sample_taken,
  output logic                   out_running,
  output logic                   out_calibration_done,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CfgIndexW-1:0]   cfg_index,
  input  logic [CfgDataW-1:0]    cfg_data
);

  cfg_t                   cfg;
  logic                   in_vld_r, out_vld_r;
  logic                   advance, fire;
  action_t                in_action_r;
  logic [TIME_BITS-1:0]   in_time_r;
  logic [SAMPLE_BITS-1:0] in_raw_r;
  logic                   in_dig_r;
  logic [SAMPLE_BITS-1:0] filt_nxt, out_filt_r;
  flags_t                 flags_nxt, out_flags_r;

  assign advance   = !out_vld_r || out_ready;
  assign fire      = in_vld_r && advance;
  assign in_ready  = !in_vld_r || advance;
  assign cfg_ready = 1'b1;

  sta_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  sta_engine #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .CAL_SAMPLES (CAL_SAMPLES),
    .TIME_BITS   (TIME_BITS)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .action  (in_action_r),
    .now     (in_time_r),
    .raw     (in_raw_r),
    .dig     (in_dig_r),
    .cfg     (cfg),
    .filt_o  (filt_nxt),
    .flags_o (flags_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= in_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_action_r <= action_t'(in_action);
      in_time_r   <= in_time_ms;
      in_raw_r    <= in_raw_sample;
      in_dig_r    <= in_raw_digital;
    end
    if (fire) begin
      out_filt_r  <= filt_nxt;
      out_flags_r <= flags_nxt;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_smoothed_value   = out_filt_r;
  assign out_alarm            = out_flags_r.alarm;
  assign out_digital_level    = out_flags_r.digital_level;
  assign out_sample_taken     = out_flags_r.sample_taken;
  assign out_running          = out_flags_r.running;
  assign out_calibration_done = out_flags_r.calibration_done;

  a_taken_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_flags_r.sample_taken |-> out_flags_r.running)
    else $error("sample taken while not running");

  a_req_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !advance |=> in_vld_r)
    else $error("stalled request dropped");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_action_r == ACT_START |=>
      out_vld_r && !out_flags_r.alarm && out_flags_r.running)
    else $error("start did not clear alarm");

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// Testbench for smoothed_threshold_alarm_debounce: directed and random requests,
// with every result checked against a cycle-free model of the filter, debounce and
// calibration logic kept in the bench. Depends on sta_pkg and the RTL top level.
module tb;
  import sta_pkg::*;

  localparam int SAMPLE_BITS = 12;
  localparam int CAL_SAMPLES = 10;
  localparam int TIME_BITS   = 32;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PRINT_LIMIT = 200;

  localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [2:0] ACT_UNUSED_HI = 3'd7;
  localparam logic [CfgIndexW-1:0] REG_UNUSED = 3'd6;
  localparam logic [SAMPLE_BITS-1:0] RAW_MAX = '1;

  typedef struct {
    logic [SAMPLE_BITS-1:0] smoothed_value;
    logic                   alarm;
    logic                   digital_level;
    logic                   sample_taken;
    logic                   running;
    logic                   calibration_done;
  } alarm_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [2:0]             in_action = ACT_SAMPLE;
  logic [TIME_BITS-1:0]   in_time_ms = '0;
  logic [SAMPLE_BITS-1:0] in_raw_sample = '0;
  logic                   in_raw_digital = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [SAMPLE_BITS-1:0] out_smoothed_value;
  logic                   out_alarm;
  logic                   out_digital_level;
  logic                   out_sample_taken;
  logic                   out_running;
  logic                   out_calibration_done;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CfgIndexW-1:0]   cfg_index = REG_THRESHOLD;
  logic [CfgDataW-1:0]    cfg_data = '0;

  // register copies
  logic [11:0] set_threshold = THRESHOLD_RST;
  logic [15:0] set_interval  = INTERVAL_RST;
  logic [15:0] set_debounce  = DEBOUNCE_RST;
  logic [3:0]  set_alpha     = ALPHA_RST;

  // block state copies
  logic [SAMPLE_BITS-1:0] pred_filter = '0;
  logic [TIME_BITS-1:0]   pred_last_time = '0;
  logic                   pred_pending = 1'b0;
  logic [TIME_BITS-1:0]   pred_change_time = '0;
  logic                   pred_alarm = 1'b0;
  logic                   pred_digital = 1'b0;
  logic                   pred_active = 1'b0;
  logic [15:0]            pred_cal_sum = '0;
  logic [3:0]             pred_cal_count = '0;

  alarm_result_t alarm_results_due[$];
  int unsigned   error_count = 0;
  int unsigned   cycle_count = 0;
  int            stall_len = 0;
  bit            steady = 1'b0;
  logic [TIME_BITS-1:0] stim_time = '0;

  smoothed_threshold_alarm_debounce #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .CAL_SAMPLES(CAL_SAMPLES),
    .TIME_BITS  (TIME_BITS)
  ) DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_action           (in_action),
    .in_time_ms          (in_time_ms),
    .in_raw_sample       (in_raw_sample),
    .in_raw_digital      (in_raw_digital),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_smoothed_value  (out_smoothed_value),
    .out_alarm           (out_alarm),
    .out_digital_level   (out_digital_level),
    .out_sample_taken    (out_sample_taken),
    .out_running         (out_running),
    .out_calibration_done(out_calibration_done),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic alarm_result_t next_alarm_result(logic [2:0] act,
      logic [TIME_BITS-1:0] now, logic [SAMPLE_BITS-1:0] raw, logic dig);
    alarm_result_t r;
    int unsigned   a;
    int unsigned   acc;
    logic          cond;
    r.sample_taken     = 1'b0;
    r.calibration_done = 1'b0;
    case (act)
      ACT_SAMPLE: begin
        if (pred_active && TIME_BITS'(now - pred_last_time) >= set_interval) begin
          a = (set_alpha > ALPHA_FULL) ? ALPHA_FULL : set_alpha;
          acc = a * raw + (int'(ALPHA_FULL) - a) * pred_filter;
          pred_last_time = now;
          pred_filter    = SAMPLE_BITS'(acc / ALPHA_FULL);
          pred_digital   = dig;
          cond = (pred_filter >= set_threshold);
          if (cond != pred_alarm) begin
            if (!pred_pending) begin
              pred_pending     = 1'b1;
              pred_change_time = now;
            end else if (TIME_BITS'(now - pred_change_time) >= set_debounce) begin
              pred_alarm   = cond;
              pred_pending = 1'b0;
            end
          end else begin
            pred_pending = 1'b0;
          end
          r.sample_taken = 1'b1;
        end
      end
      ACT_REBASELINE: begin
        pred_filter  = raw;
        pred_alarm   = 1'b0;
        pred_pending = 1'b0;
      end
      ACT_CAL_SAMPLE: begin
        pred_cal_sum   = pred_cal_sum + raw;
        pred_cal_count = pred_cal_count + 4'd1;
        if (pred_cal_count >= CAL_SAMPLES) begin
          pred_filter        = SAMPLE_BITS'(pred_cal_sum / CAL_SAMPLES);
          pred_cal_sum       = '0;
          pred_cal_count     = '0;
          r.calibration_done = 1'b1;
        end
      end
      ACT_STOP: pred_active = 1'b0;
      ACT_START: begin
        pred_filter      = '0;
        pred_last_time   = '0;
        pred_pending     = 1'b0;
        pred_change_time = '0;
        pred_alarm       = 1'b0;
        pred_digital     = 1'b0;
        pred_active      = 1'b1;
      end
      default: ;
    endcase
    r.smoothed_value = pred_filter;
    r.alarm          = pred_alarm;
    r.digital_level  = pred_digital;
    r.running        = pred_active;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (error_count < PRINT_LIMIT)
      $display("tb: mismatch %s got %0h want %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  task automatic send_request(logic [2:0] act, logic [TIME_BITS-1:0] now,
      logic [SAMPLE_BITS-1:0] raw, logic dig);
    if (!steady && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_time_ms     <= now;
    in_raw_sample  <= raw;
    in_raw_digital <= dig;
    do @(posedge clk); while (!in_ready);
    alarm_results_due.push_back(next_alarm_result(act, now, raw, dig));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (alarm_results_due.size() != 0);
  endtask

  task automatic cfg_write(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_THRESHOLD: set_threshold = data[11:0];
      REG_INTERVAL:  set_interval  = data;
      REG_DEBOUNCE:  set_debounce  = data;
      REG_ALPHA:     set_alpha     = data[3:0];
      default: ;
    endcase
  endtask

  // upper data bits are random: the block keeps only the register width
  task automatic write_config(logic [11:0] thr, logic [15:0] intv, logic [15:0] dbn,
      logic [3:0] alpha, bit poke_unused);
    drain_results();
    if (poke_unused)
      cfg_write(REG_UNUSED, CfgDataW'($urandom));
    cfg_write(REG_THRESHOLD, {4'($urandom), thr});
    cfg_write(REG_INTERVAL, intv);
    cfg_write(REG_DEBOUNCE, dbn);
    cfg_write(REG_ALPHA, {12'($urandom), alpha});
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_request();
    logic [2:0]             act;
    logic [SAMPLE_BITS-1:0] raw;
    int                     near;
    int unsigned            pick;
    int unsigned            span;
    pick = $urandom_range(99);
    if (pick < 68)      act = ACT_SAMPLE;
    else if (pick < 73) act = ACT_REBASELINE;
    else if (pick < 85) act = ACT_CAL_SAMPLE;
    else if (pick < 89) act = ACT_STOP;
    else if (pick < 95) act = ACT_START;
    else                act = 3'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO));
    if (!pred_active && act == ACT_SAMPLE && $urandom_range(3) != 0)
      act = ACT_START;
    span = 2 * set_interval + set_debounce / 3 + 20;
    if ($urandom_range(49) == 0) stim_time = $urandom();
    else stim_time = stim_time + $urandom_range(span, 0);
    case ($urandom_range(3))
      0: raw = SAMPLE_BITS'($urandom());
      1: begin
        near = int'(set_threshold) + $urandom_range(128) - 64;
        raw = (near < 0) ? '0 : (near > int'(RAW_MAX)) ? RAW_MAX : SAMPLE_BITS'(near);
      end
      2: raw = $urandom_range(1) ? RAW_MAX : '0;
      default: raw = SAMPLE_BITS'($urandom_range(127));
    endcase
    send_request(act, stim_time, raw, 1'($urandom()));
  endtask

  task automatic test_stopped_and_unused();
    send_request(ACT_SAMPLE, 32'd1000, RAW_MAX, 1'b1);
    send_request(ACT_UNUSED_LO, 32'd1100, RAW_MAX, 1'b1);
    send_request(ACT_UNUSED_HI, 32'd1200, '0, 1'b0);
    send_request(ACT_REBASELINE, 32'd1300, RAW_MAX, 1'b0);
  endtask

  task automatic test_filter_and_debounce();
    send_request(ACT_START, 32'd0, '0, 1'b0);
    send_request(ACT_SAMPLE, 32'd100, RAW_MAX, 1'b1);
    send_request(ACT_SAMPLE, 32'd200, RAW_MAX, 1'b1);
    send_request(ACT_SAMPLE, 32'd400, RAW_MAX, 1'b1);
    send_request(ACT_SAMPLE, 32'd1200, '0, 1'b0);
    send_request(ACT_SAMPLE, 32'd1400, '0, 1'b1);
    send_request(ACT_REBASELINE, 32'd1500, '0, 1'b0);
    send_request(ACT_SAMPLE, 32'hFFFF_FF00, RAW_MAX, 1'b1);
    send_request(ACT_SAMPLE, 32'h0000_0010, RAW_MAX, 1'b0);
    send_request(ACT_STOP, 32'h0000_0100, '0, 1'b0);
    send_request(ACT_SAMPLE, 32'h0001_0000, RAW_MAX, 1'b1);
  endtask

  task automatic test_calibration();
    repeat (4) send_request(ACT_CAL_SAMPLE, 32'd5000, RAW_MAX, 1'b1);
    send_request(ACT_START, 32'd5000, '0, 1'b0);
    repeat (6) send_request(ACT_CAL_SAMPLE, 32'd5000, RAW_MAX, 1'b0);
  endtask

  task automatic test_config_extremes();
    logic [11:0] thr[5]   = '{12'd0, 12'd4095, 12'd100, 12'd2000, THRESHOLD_RST};
    logic [15:0] intv[5]  = '{16'd0, 16'd65535, 16'd0, 16'd50, INTERVAL_RST};
    logic [15:0] dbn[5]   = '{16'd0, 16'd65535, 16'd0, 16'd300, DEBOUNCE_RST};
    logic [3:0]  alpha[5] = '{4'd0, ALPHA_FULL, 4'd15, 4'd1, ALPHA_RST};
    for (int p = 0; p < 5; p++) begin
      write_config(thr[p], intv[p], dbn[p], alpha[p], p == 0);
      send_request(ACT_START, stim_time, '0, 1'b0);
      repeat (100) send_random_request();
    end
  endtask

  task automatic test_backpressure();
    drain_results();
    stall_len = 80;
    repeat (40) send_random_request();
    drain_results();
  endtask

  task automatic test_random();
    steady = 1'b1;
    repeat (400) send_random_request();
    steady = 1'b0;
    repeat (1100) send_random_request();
  endtask

  always @(posedge clk) begin
    alarm_result_t want;
    if (out_valid && out_ready) begin
      if (alarm_results_due.size() == 0) begin
        report_mismatch("unexpected result", out_smoothed_value, '0);
      end else begin
        want = alarm_results_due.pop_front();
        if (out_smoothed_value !== want.smoothed_value)
          report_mismatch("smoothed_value", out_smoothed_value, want.smoothed_value);
        if (out_alarm !== want.alarm)
          report_mismatch("alarm", out_alarm, want.alarm);
        if (out_digital_level !== want.digital_level)
          report_mismatch("digital_level", out_digital_level, want.digital_level);
        if (out_sample_taken !== want.sample_taken)
          report_mismatch("sample_taken", out_sample_taken, want.sample_taken);
        if (out_running !== want.running)
          report_mismatch("running", out_running, want.running);
        if (out_calibration_done !== want.calibration_done)
          report_mismatch("calibration_done", out_calibration_done, want.calibration_done);
      end
    end
    if (stall_len > 0) begin
      out_ready <= 1'b0;
      stall_len--;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= 13);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_stopped_and_unused();
    test_filter_and_debounce();
    test_calibration();
    test_config_extremes();
    test_backpressure();
    test_random();
    drain_results();
    repeat (20) @(posedge clk);
    if (alarm_results_due.size() != 0)
      report_mismatch("results left over", alarm_results_due.size(), '0);
    if (error_count == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule

@@ files.f @@
hdl/sta_pkg.sv
hdl/sta_cfg_regs.sv
hdl/sta_engine.sv
hdl/smoothed_threshold_alarm_debounce.sv
dv/tb.sv
